// ----- hw/rtl/bd3_pkg.sv -----
// Shared types and constants for the 3D box difference block.
`timescale 1ns / 1ps

package bd3_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int NUM_DIMS    = 3;
    localparam int NUM_PIECES  = 2 * NUM_DIMS;

    // Twelve input coordinates and six output coordinates, padded to whole bytes.
    localparam int IN_FIELDS  = 4 * NUM_DIMS;
    localparam int OUT_FIELDS = 2 * NUM_DIMS;
    localparam int IN_DATA_W  = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_FIELDS * COORD_WIDTH + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // Index 0 is x, 1 is y, 2 is z.
    typedef t_coord [NUM_DIMS-1:0] t_point;

    typedef struct packed {
        t_point lo;
        t_point hi;
    } t_box;

    // Candidate pieces for one box pair and which of them are real.
    typedef struct packed {
        t_box [NUM_PIECES-1:0]  piece;
        logic [NUM_PIECES-1:0]  mask;
    } t_split;

endpackage

// ----- hw/rtl/bd3_split.sv -----
// Combinational split of box A minus box B into up to six candidate slabs.
`timescale 1ns / 1ps

module bd3_split (
    input  bd3_pkg::t_box   i_box_a,
    input  bd3_pkg::t_box   i_box_b,
    output bd3_pkg::t_split o_split
);
    import bd3_pkg::*;

    t_point w_ilo;
    t_point w_ihi;
    logic   w_a_empty;
    logic   w_b_empty;
    logic   w_overlap;
    t_split w_split;

    always_comb begin
        w_a_empty = 1'b0;
        w_b_empty = 1'b0;
        w_overlap = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if ($signed(i_box_a.lo[d]) >= $signed(i_box_a.hi[d])) begin
                w_a_empty = 1'b1;
            end
            if ($signed(i_box_b.lo[d]) >= $signed(i_box_b.hi[d])) begin
                w_b_empty = 1'b1;
            end
            if (!(($signed(i_box_a.lo[d]) < $signed(i_box_b.hi[d])) &&
                  ($signed(i_box_b.lo[d]) < $signed(i_box_a.hi[d])))) begin
                w_overlap = 1'b0;
            end
            w_ilo[d] = ($signed(i_box_a.lo[d]) > $signed(i_box_b.lo[d])) ?
                       i_box_a.lo[d] : i_box_b.lo[d];
            w_ihi[d] = ($signed(i_box_a.hi[d]) < $signed(i_box_b.hi[d])) ?
                       i_box_a.hi[d] : i_box_b.hi[d];
        end
    end

    // Slab pair for dimension d: dimensions below d take the intersection
    // extent, the rest take the extent of A; dimension d covers the gap.
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            for (int e = 0; e < NUM_DIMS; e++) begin
                if (e < d) begin
                    w_split.piece[2*d].lo[e]   = w_ilo[e];
                    w_split.piece[2*d].hi[e]   = w_ihi[e];
                    w_split.piece[2*d+1].lo[e] = w_ilo[e];
                    w_split.piece[2*d+1].hi[e] = w_ihi[e];
                end else begin
                    w_split.piece[2*d].lo[e]   = i_box_a.lo[e];
                    w_split.piece[2*d].hi[e]   = i_box_a.hi[e];
                    w_split.piece[2*d+1].lo[e] = i_box_a.lo[e];
                    w_split.piece[2*d+1].hi[e] = i_box_a.hi[e];
                end
            end
            w_split.piece[2*d].hi[d]   = w_ilo[d];
            w_split.piece[2*d+1].lo[d] = w_ihi[d];
            w_split.mask[2*d]   = $signed(i_box_a.lo[d]) < $signed(w_ilo[d]);
            w_split.mask[2*d+1] = $signed(i_box_a.hi[d]) > $signed(w_ihi[d]);
        end
    end

    always_comb begin
        o_split = w_split;
        if (w_a_empty) begin
            o_split.mask = '0;
        end else if (w_b_empty || !w_overlap) begin
            // Disjoint or empty B: pass A through as the only piece.
            o_split.mask     = NUM_PIECES'(1);
            o_split.piece[0] = i_box_a;
        end
    end

endmodule

// ----- hw/rtl/box_difference_3d_core.sv -----
// Top level of the 3D box difference block: input register, split, piece output register.
`timescale 1ns / 1ps

// Channel  | dir | handshake           | contents
// ---------+-----+---------------------+------------------------------------------
// s (in)   | in  | i_s_tvalid/o_s_tready | box pair A, B (twelve coordinates)
// m (out)  | out | o_m_tvalid/i_m_tready | one result piece (six coordinates), tlast
//
// An accepted pair sits in the input register; while the output is not stalled,
// one piece per cycle moves from there into the output register. A pair gives
// between one and six pieces, or none (A empty or inside B). The next pair is
// taken in the same cycle that the last piece of the current one moves to the
// output register, so single-piece pairs stream at one a cycle without stalls.
// A stall on the output side holds the output register and then the input one.
// Reset is synchronous, active low, and clears only the valid and progress bits.
module box_difference_3d_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // a_low_x, a_low_y, a_low_z, a_high_x, a_high_y, a_high_z,
    // b_low_x, b_low_y, b_low_z, b_high_x, b_high_y, b_high_z
    input  logic [bd3_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // piece_low_x, piece_low_y, piece_low_z, piece_high_x, piece_high_y, piece_high_z
    output logic [bd3_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // last_piece
    output logic                        o_m_tlast
);
    import bd3_pkg::*;

    // Input stage.
    logic                   r_in_valid;
    logic [NUM_PIECES-1:0]  r_sent;
    t_box                   r_box_a;
    t_box                   r_box_b;
    t_box                   n_box_a;
    t_box                   n_box_b;

    // Output stage.
    logic                   r_out_valid;
    t_box                   r_out_box;
    logic                   r_out_last;

    t_split                 w_split;
    logic [NUM_PIECES-1:0]  w_remain;
    logic [NUM_PIECES-1:0]  w_pick;
    logic [NUM_PIECES-1:0]  w_remain_after;
    t_box                   w_piece;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_item_done;
    logic                   w_in_xfer;

    // Unpack the input word: field k sits at bits k*COORD_WIDTH upward.
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            n_box_a.lo[d] = i_s_tdata[d*COORD_WIDTH +: COORD_WIDTH];
            n_box_a.hi[d] = i_s_tdata[(NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH];
            n_box_b.lo[d] = i_s_tdata[(2*NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH];
            n_box_b.hi[d] = i_s_tdata[(3*NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    bd3_split u_split (
        .i_box_a (r_box_a),
        .i_box_b (r_box_b),
        .o_split (w_split)
    );

    // Pieces still owed for the held pair; take the lowest in emit order.
    assign w_remain       = w_split.mask & ~r_sent;
    assign w_pick         = w_remain & (~w_remain + NUM_PIECES'(1));
    assign w_remain_after = w_remain & ~w_pick;

    always_comb begin
        w_piece = '0;
        for (int k = 0; k < NUM_PIECES; k++) begin
            if (w_pick[k]) begin
                w_piece = w_split.piece[k];
            end
        end
    end

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_emit      = r_in_valid && (w_remain != '0) && w_out_free;
    // The pair is finished when nothing is left, or the last piece moves now.
    assign w_item_done = r_in_valid &&
                         ((w_remain == '0) || (w_emit && (w_remain_after == '0)));
    assign o_s_tready  = !r_in_valid || w_item_done;
    assign w_in_xfer   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
                r_sent     <= '0;
            end else if (w_item_done) begin
                r_in_valid <= 1'b0;
                r_sent     <= '0;
            end else if (w_emit) begin
                r_sent <= r_sent | w_pick;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_box_a <= n_box_a;
            r_box_b <= n_box_b;
        end
        if (w_emit) begin
            r_out_box  <= w_piece;
            r_out_last <= (w_remain_after == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        o_m_tdata = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            o_m_tdata[d*COORD_WIDTH +: COORD_WIDTH]            = r_out_box.lo[d];
            o_m_tdata[(NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH] = r_out_box.hi[d];
        end
    end

`ifndef SYNTH
    // Progress bits never mark a piece that the held pair does not have.
    a_sent_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> ((r_sent & ~w_split.mask) == '0))
        else $error("progress bits outside piece mask");

    // A stalled input side means a pair is still being worked on.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid)
        else $error("input stalled with no pair held");

    // Every piece that is presented is a nonempty box.
    a_piece_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (($signed(r_out_box.lo[0]) < $signed(r_out_box.hi[0])) &&
                        ($signed(r_out_box.lo[1]) < $signed(r_out_box.hi[1])) &&
                        ($signed(r_out_box.lo[2]) < $signed(r_out_box.hi[2]))))
        else $error("empty piece presented");

    // A piece moves out only while a pair is held.
    a_emit_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_in_valid))
        else $error("piece presented without a source pair");
`endif

endmodule

// ----- test/box_difference_3d_core_tb.sv -----
// Self-checking testbench for box_difference_3d_core: box pairs in, predicted pieces checked.
`timescale 1ns / 1ps

module box_difference_3d_core_tb;

    import bd3_pkg::*;

    localparam int   RESET_CYCLES  = 6;
    localparam int   WATCHDOG_MAX  = 1000;
    localparam int   DRAIN_CYCLES  = 12;
    localparam t_coord COORD_MIN   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord COORD_MAX   = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    // One expected result piece and its end-of-pair flag.
    typedef struct {
        t_box box;
        logic last;
    } t_piece_exp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // a_low_x, a_low_y, a_low_z, a_high_x, a_high_y, a_high_z,
    // b_low_x, b_low_y, b_low_z, b_high_x, b_high_y, b_high_z
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // piece_low_x, piece_low_y, piece_low_z, piece_high_x, piece_high_y, piece_high_z
    logic [OUT_DATA_W-1:0] o_m_tdata;
    // last_piece
    logic                  o_m_tlast;

    t_piece_exp pending_pieces[$];
    int         error_count   = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles  = 0;

    string piece_field_name[OUT_FIELDS] = '{"piece_low_x", "piece_low_y", "piece_low_z",
                                            "piece_high_x", "piece_high_y", "piece_high_z"};

    box_difference_3d_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_box make_box(input t_coord lx, input t_coord ly, input t_coord lz,
                                      input t_coord hx, input t_coord hy, input t_coord hz);
        t_box bx;
        bx.lo[0] = lx;
        bx.lo[1] = ly;
        bx.lo[2] = lz;
        bx.hi[0] = hx;
        bx.hi[1] = hy;
        bx.hi[2] = hz;
        return bx;
    endfunction

    // Work out the pieces of A minus B and queue them in output order.
    // A slab keeps A's extent in the dimensions still to come and the
    // overlap's extent in the ones already cut.
    task automatic carve_pieces(input t_box a, input t_box b);
        t_point     ilo;
        t_point     ihi;
        t_point     rlo;
        t_point     rhi;
        t_box       cut;
        t_box       found[$];
        t_piece_exp entry;
        bit         a_empty;
        bit         b_empty;
        bit         overlap;
        a_empty = 1'b0;
        b_empty = 1'b0;
        overlap = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if ($signed(a.lo[d]) >= $signed(a.hi[d])) a_empty = 1'b1;
            if ($signed(b.lo[d]) >= $signed(b.hi[d])) b_empty = 1'b1;
            if (!($signed(a.lo[d]) < $signed(b.hi[d]) && $signed(b.lo[d]) < $signed(a.hi[d])))
                overlap = 1'b0;
        end
        // An empty A leaves nothing behind.
        if (a_empty) return;
        // Disjoint, touching or empty B: A passes through whole.
        if (b_empty || !overlap) begin
            entry.box  = a;
            entry.last = 1'b1;
            pending_pieces.insert(pending_pieces.size(), entry);
            return;
        end
        for (int d = 0; d < NUM_DIMS; d++) begin
            ilo[d] = ($signed(a.lo[d]) > $signed(b.lo[d])) ? a.lo[d] : b.lo[d];
            ihi[d] = ($signed(a.hi[d]) < $signed(b.hi[d])) ? a.hi[d] : b.hi[d];
        end
        rlo = a.lo;
        rhi = a.hi;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if ($signed(a.lo[d]) < $signed(ilo[d])) begin
                cut.lo    = rlo;
                cut.hi    = rhi;
                cut.lo[d] = a.lo[d];
                cut.hi[d] = ilo[d];
                found.insert(found.size(), cut);
            end
            if ($signed(a.hi[d]) > $signed(ihi[d])) begin
                cut.lo    = rlo;
                cut.hi    = rhi;
                cut.lo[d] = ihi[d];
                cut.hi[d] = a.hi[d];
                found.insert(found.size(), cut);
            end
            rlo[d] = ilo[d];
            rhi[d] = ihi[d];
        end
        foreach (found[k]) begin
            entry.box  = found[k];
            entry.last = (k == found.size() - 1);
            pending_pieces.insert(pending_pieces.size(), entry);
        end
    endtask

    // Offer one box pair and hold it until the transfer; queue its pieces then.
    // Valid stays high after the transfer so back-to-back pairs stream.
    task automatic send_pair(input t_box a, input t_box b);
        logic [IN_DATA_W-1:0] word;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            word[(d)*COORD_WIDTH +: COORD_WIDTH]                = a.lo[d];
            word[(NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH]       = a.hi[d];
            word[(2*NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH]     = b.lo[d];
            word[(3*NUM_DIMS+d)*COORD_WIDTH +: COORD_WIDTH]     = b.hi[d];
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        carve_pieces(a, b);
    endtask

    // Pick a coordinate from the edges of the range, around zero, or anywhere.
    function automatic t_coord corner_coord();
        case ($urandom_range(6))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return COORD_MIN + 1;
            3: return COORD_MAX - 1;
            4: return '0;
            5: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Hand-picked pairs: each special case of the split plus the range edges.
    task automatic test_directed_cases();
        // Disjoint along x: A passes through.
        send_pair(make_box(0, 0, 0, 4, 4, 4), make_box(10, 0, 0, 14, 4, 4));
        // Shared face only: still no overlap.
        send_pair(make_box(0, 0, 0, 4, 4, 4), make_box(4, 0, 0, 8, 4, 4));
        // A inside B, and A equal to B: nothing left.
        send_pair(make_box(1, 1, 1, 3, 3, 3), make_box(0, 0, 0, 4, 4, 4));
        send_pair(make_box(0, 0, 0, 4, 4, 4), make_box(0, 0, 0, 4, 4, 4));
        // B strictly inside A: all six slabs.
        send_pair(make_box(0, 0, 0, 10, 10, 10), make_box(3, 3, 3, 6, 6, 6));
        // Empty A, flat and inverted.
        send_pair(make_box(0, 0, 0, 0, 5, 5), make_box(0, 0, 0, 5, 5, 5));
        send_pair(make_box(5, 0, 0, 2, 5, 5), make_box(0, 0, 0, 5, 5, 5));
        // Empty B inside A's span: A passes through.
        send_pair(make_box(0, 0, 0, 5, 5, 5), make_box(1, 1, 1, 1, 4, 4));
        // B eats the x-low side and everything but the z-high cap.
        send_pair(make_box(0, 0, 0, 10, 10, 10), make_box(-5, -5, -5, 3, 20, 20));
        send_pair(make_box(0, 0, 0, 10, 10, 10), make_box(-5, -5, -5, 20, 20, 7));
        // Only the x slabs remain.
        send_pair(make_box(0, 0, 0, 10, 10, 10), make_box(2, -5, -5, 4, 15, 15));
        // Overlap in x and z but disjoint in y.
        send_pair(make_box(0, 0, 0, 10, 10, 10), make_box(2, 12, 2, 4, 15, 4));
        // Negative coordinates, partial overlap.
        send_pair(make_box(-20, -20, -20, -10, -10, -10), make_box(-15, -25, -12, -11, -5, 0));
        // Full range A with a small hole around zero: six slabs at the edges.
        send_pair(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
                  make_box(-1, -1, -1, 1, 1, 1));
        // Full range on both sides: nothing left.
        send_pair(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
                  make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        // Full range A minus its lower octant.
        send_pair(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
                  make_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
        // Single cells at the top and bottom of the range.
        send_pair(make_box(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX - 1,
                           COORD_MAX, COORD_MAX, COORD_MAX),
                  make_box(COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MIN + 1, COORD_MIN + 1, COORD_MIN + 1));
        send_pair(make_box(COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MIN + 1, COORD_MIN + 1, COORD_MIN + 1),
                  make_box(COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MIN + 1, COORD_MIN + 1, COORD_MIN + 1));
    endtask

    // Random pairs: mostly small boxes near a shared base so they overlap often,
    // the rest fully random words and corner values.
    task automatic test_random_pairs(input int count);
        t_box   a;
        t_box   b;
        t_coord base;
        repeat (count) begin
            base = $signed($urandom) >>> 1;
            case ($urandom_range(9))
                0, 1: begin
                    for (int d = 0; d < NUM_DIMS; d++) begin
                        a.lo[d] = $urandom;
                        a.hi[d] = $urandom;
                        b.lo[d] = $urandom;
                        b.hi[d] = $urandom;
                    end
                end
                2: begin
                    for (int d = 0; d < NUM_DIMS; d++) begin
                        a.lo[d] = corner_coord();
                        a.hi[d] = corner_coord();
                        b.lo[d] = corner_coord();
                        b.hi[d] = corner_coord();
                    end
                end
                default: begin
                    for (int d = 0; d < NUM_DIMS; d++) begin
                        a.lo[d] = base + $urandom_range(12);
                        a.hi[d] = ($urandom_range(19) == 0) ? a.lo[d] - $urandom_range(2)
                                                            : a.lo[d] + $urandom_range(1, 12);
                        b.lo[d] = base + $urandom_range(16) - 2;
                        b.hi[d] = ($urandom_range(19) == 0) ? b.lo[d] - $urandom_range(2)
                                                            : b.lo[d] + $urandom_range(1, 14);
                    end
                end
            endcase
            send_pair(a, b);
        end
    endtask

    // Output side: stall at random and check each transfer against the oldest
    // expected piece.
    always @(posedge i_clk) begin
        t_piece_exp exp_piece;
        t_coord     want;
        t_coord     got;
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pieces.size() == 0) begin
                $error("unexpected piece: data %h last %0b", o_m_tdata, o_m_tlast);
                error_count++;
            end else begin
                exp_piece = pending_pieces.pop_front();
                for (int f = 0; f < OUT_FIELDS; f++) begin
                    want = (f < NUM_DIMS) ? exp_piece.box.lo[f] : exp_piece.box.hi[f-NUM_DIMS];
                    got  = o_m_tdata[f*COORD_WIDTH +: COORD_WIDTH];
                    if (got !== want) begin
                        $error("%s: expected %0d, got %0d", piece_field_name[f], want, got);
                        error_count++;
                    end
                end
                if (o_m_tlast !== exp_piece.last) begin
                    $error("last_piece: expected %0b, got %0b", exp_piece.last, o_m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls often.
        send_idle_pct  = 20;
        recv_stall_pct = 54;
        test_directed_cases();
        test_random_pairs(34);

        // Swap the roles: sparse input, eager output.
        send_idle_pct  = 54;
        recv_stall_pct = 20;
        test_random_pairs(58);

        // Full rate on both sides.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_pairs(60);

        // Drop valid after the last transfer, drain, then let the pipeline settle.
        i_s_tvalid <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bd3_pkg.sv
hw/rtl/bd3_split.sv
hw/rtl/box_difference_3d_core.sv
test/box_difference_3d_core_tb.sv
